### rtl/rcm_pkg.sv
`default_nettype none
package rcm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;

  // Register stages of the sine/cosine unit: two reduction stages, the CORDIC
  // stages and one rounding stage.
  localparam int SC_LATENCY    = CORDIC_STAGES + 3;
  // Matrix products, entry rounding and translation add five more stages.
  localparam int TOTAL_LATENCY = SC_LATENCY + 5;

  localparam int XW = 34;  // CORDIC x/y, Q2.30 with headroom
  localparam int ZW = 32;  // CORDIC angle, Q3.28
  localparam int TW = 18;  // sine/cosine and rotation entries, Q1.16
  localparam int SW = 28;  // translations, Q16.12

  localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
  localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
  localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_Q30  = 34'sd652032874;
  localparam logic signed [TW-1:0] ONE_Q16   = 18'sd65536;

  localparam logic signed [ZW-1:0] ATAN_Q28 [ATAN_ENTRIES] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571, 32'sd524287,
    32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
    32'sd32
  };

endpackage
`default_nettype wire

### rtl/rotation_about_center_matrix_top.sv
// Channel   Direction  Content
// s_axis    in         angle_x, angle_y, angle_z, pivot_x, pivot_y, pivot_z
// m_axis    out        three matrix rows: rot_r0, rot_r1, rot_r2, shift_r
//
// One item per cycle is accepted unless the pipeline holds.
// The pipeline advances as one whole; it holds when the output register is
// full and m_axis_tready is low, and s_axis_tready is low only then.
// rst clears the valid bits; data registers are not reset.
`default_nettype none
module rotation_about_center_matrix_top
  import rcm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // angle_x[15:0], angle_y[31:16], angle_z[47:32],
  // pivot_x[71:48], pivot_y[95:72], pivot_z[119:96]
  input  wire logic [119:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // rot_00, rot_01, rot_02, shift_0, rot_10, rot_11, rot_12, shift_1,
  // rot_20, rot_21, rot_22, shift_2, two zero bits
  output logic [247:0]      m_axis_tdata
);

  localparam int PD = SC_LATENCY + 4;

  logic                 adv;
  logic                 vld [TOTAL_LATENCY];
  logic [71:0]          pd [PD];
  logic signed [TW-1:0] sx, cx, sy, cy, sz, cz;

  // First product stage.
  logic signed [TW-1:0] p1_sx, p1_cx, p1_sy, p1_cy, p1_sz, p1_cz;
  logic signed [35:0]   p_ss, p_sc, p_cc, p_cs;
  // Second product stage.
  logic signed [53:0]   m_zss, m_sxc, m_zsc, m_ssx, m_sss, m_ccx, m_ssc, m_csx;
  logic signed [53:0]   m_zcy, m_scy;
  logic signed [TW-1:0] p2_sy;
  logic signed [35:0]   p2_cs, p2_cc;
  logic signed [55:0]   e [3][3];
  logic signed [TW-1:0] ent [3][3];
  logic signed [TW-1:0] ent4 [3][3];
  logic signed [41:0]   q [3][3];
  logic signed [TW-1:0] ent_o [3][3];
  logic signed [SW-1:0] sh_o [3];
  logic signed [23:0]   pv4 [3];
  logic signed [23:0]   pv5 [3];
  logic signed [45:0]   tsum [3];
  logic signed [45:0]   tr [3];

  function automatic logic signed [TW-1:0] round_entry(input logic signed [55:0] v);
    logic signed [55:0] s;
    s = (v + 56'sd2147483648) >>> 32;
    if (s > 56'(ONE_Q16)) begin
      return ONE_Q16;
    end else if (s < -56'(ONE_Q16)) begin
      return -ONE_Q16;
    end
    return TW'(s);
  endfunction

  assign adv           = !vld[TOTAL_LATENCY-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[TOTAL_LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TOTAL_LATENCY; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < TOTAL_LATENCY; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pd[0] <= s_axis_tdata[119:48];
      for (int k = 1; k < PD; k++) begin
        pd[k] <= pd[k-1];
      end
    end
  end

  rcm_sincos u_sc_x (.clk(clk), .en(adv), .angle(s_axis_tdata[15:0]),
                     .sin_o(sx), .cos_o(cx));
  rcm_sincos u_sc_y (.clk(clk), .en(adv), .angle(s_axis_tdata[31:16]),
                     .sin_o(sy), .cos_o(cy));
  rcm_sincos u_sc_z (.clk(clk), .en(adv), .angle(s_axis_tdata[47:32]),
                     .sin_o(sz), .cos_o(cz));

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ss  <= sy * sx;
      p_sc  <= sy * cx;
      p_cc  <= cy * cx;
      p_cs  <= cy * sx;
      p1_sx <= sx;
      p1_cx <= cx;
      p1_sy <= sy;
      p1_cy <= cy;
      p1_sz <= sz;
      p1_cz <= cz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_zss <= p1_cz * p_ss;
      m_sxc <= 54'(p1_sz * p1_cx);
      m_zsc <= p1_cz * p_sc;
      m_ssx <= 54'(p1_sz * p1_sx);
      m_sss <= p1_sz * p_ss;
      m_ccx <= 54'(p1_cz * p1_cx);
      m_ssc <= p1_sz * p_sc;
      m_csx <= 54'(p1_cz * p1_sx);
      m_zcy <= 54'(p1_cz * p1_cy);
      m_scy <= 54'(p1_sz * p1_cy);
      p2_sy <= p1_sy;
      p2_cs <= p_cs;
      p2_cc <= p_cc;
    end
  end

  // Every entry is brought to Q48 before rounding.
  assign e[0][0] = 56'(m_zcy) <<< 16;
  assign e[0][1] = 56'(m_zss) - (56'(m_sxc) <<< 16);
  assign e[0][2] = 56'(m_zsc) + (56'(m_ssx) <<< 16);
  assign e[1][0] = 56'(m_scy) <<< 16;
  assign e[1][1] = 56'(m_sss) + (56'(m_ccx) <<< 16);
  assign e[1][2] = 56'(m_ssc) - (56'(m_csx) <<< 16);
  assign e[2][0] = -(56'(p2_sy) <<< 32);
  assign e[2][1] = 56'(p2_cs) <<< 16;
  assign e[2][2] = 56'(p2_cc) <<< 16;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          ent[r][j] <= round_entry(e[r][j]);
        end
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_piv
    assign pv4[r] = $signed(pd[SC_LATENCY+2][24*r +: 24]);
    assign pv5[r] = $signed(pd[SC_LATENCY+3][24*r +: 24]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          q[r][j]    <= ent[r][j] * pv4[j];
          ent4[r][j] <= ent[r][j];
        end
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_shift
    assign tsum[r] = (46'(pv5[r]) <<< 16) - 46'(q[r][0]) - 46'(q[r][1])
                     - 46'(q[r][2]) + 46'sd32768;
    assign tr[r]   = tsum[r] >>> 16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          ent_o[r][j] <= ent4[r][j];
        end
        if (tr[r] > 46'sd134217727) begin
          sh_o[r] <= 28'sh7FFFFFF;
        end else if (tr[r] < -46'sd134217728) begin
          sh_o[r] <= 28'sh8000000;
        end else begin
          sh_o[r] <= SW'(tr[r]);
        end
      end
    end
  end

  assign m_axis_tdata = {2'b00,
    sh_o[2], ent_o[2][2], ent_o[2][1], ent_o[2][0],
    sh_o[1], ent_o[1][2], ent_o[1][1], ent_o[1][0],
    sh_o[0], ent_o[0][2], ent_o[0][1], ent_o[0][0]};

endmodule
`default_nettype wire

### rtl/rcm_sincos.sv
`default_nettype none
module rcm_sincos
  import rcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [15:0]   angle,
  output logic signed [TW-1:0]      sin_o,
  output logic signed [TW-1:0]      cos_o
);

  logic signed [33:0]   za;
  logic signed [33:0]   zr_next;
  logic signed [33:0]   zb_next;
  logic                 neg_next;
  logic signed [XW-1:0] xs [CORDIC_STAGES+1];
  logic signed [XW-1:0] ys [CORDIC_STAGES+1];
  logic signed [ZW-1:0] zs [CORDIC_STAGES+1];
  logic                 ng [CORDIC_STAGES+1];
  logic signed [XW-1:0] xn;
  logic signed [XW-1:0] yn;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;

  // One wrap by a full turn covers the whole input range.
  always_comb begin
    zr_next = {{2{angle[15]}}, angle, 16'b0};
    if (zr_next > PI_Q28) begin
      zr_next = zr_next - TWO_PI_Q28;
    end else if (zr_next < -PI_Q28) begin
      zr_next = zr_next + TWO_PI_Q28;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      za <= zr_next;
    end
  end

  // Fold into the right half plane; sine and cosine change sign.
  always_comb begin
    zb_next  = za;
    neg_next = 1'b0;
    if (za > HALF_PI_Q28) begin
      zb_next  = za - PI_Q28;
      neg_next = 1'b1;
    end else if (za < -HALF_PI_Q28) begin
      zb_next  = za + PI_Q28;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zs[0] <= ZW'(zb_next);
      ng[0] <= neg_next;
    end
  end

  assign xs[0] = GAIN_Q30;
  assign ys[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (!zs[i][ZW-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_Q28[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_Q28[i];
        end
      end
    end
  end

  assign xn = ng[CORDIC_STAGES] ? -xs[CORDIC_STAGES] : xs[CORDIC_STAGES];
  assign yn = ng[CORDIC_STAGES] ? -ys[CORDIC_STAGES] : ys[CORDIC_STAGES];
  assign xr = (xn + XW'(8192)) >>> 14;
  assign yr = (yn + XW'(8192)) >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      if (xr > XW'(ONE_Q16)) begin
        cos_o <= ONE_Q16;
      end else if (xr < -XW'(ONE_Q16)) begin
        cos_o <= -ONE_Q16;
      end else begin
        cos_o <= TW'(xr);
      end
      if (yr > XW'(ONE_Q16)) begin
        sin_o <= ONE_Q16;
      end else if (yr < -XW'(ONE_Q16)) begin
        sin_o <= -ONE_Q16;
      end else begin
        sin_o <= TW'(yr);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/rcm_checker.sv
`default_nettype none
module rcm_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [119:0] s_axis_tdata,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [247:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // The whole pipeline stalls together, so input is refused exactly then.
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) == !s_axis_tready)
    else $error("input ready does not follow the output stall");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[247:246] == 2'b00)
    else $error("padding bits not zero");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[17:0]) <= 18'sd65536)
      && ($signed(m_axis_tdata[17:0]) >= -18'sd65536))
    else $error("rotation entry out of range");

endmodule

bind rotation_about_center_matrix_top rcm_checker u_rcm_checker (.*);
`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
  logic signed [17:0] rot [3][3];
  logic signed [27:0] shift [3];
} pose_matrix_t;

class pose_scoreboard;
  pose_matrix_t pending [$];
  int errors;

  // Sine and cosine of a Q3.12 angle, as Q1.16.
  static function void trig_q16(input logic signed [15:0] ang,
                                output longint s, output longint c);
    longint z, x, y, t;
    bit neg;
    z = longint'(ang) * 65536;
    x = 652032874;
    y = 0;
    neg = 0;
    if (z > 843314857) z -= 1686629713;
    else if (z < -843314857) z += 1686629713;
    if (z > 421657428) begin
      z -= 843314857;
      neg = 1;
    end else if (z < -421657428) begin
      z += 843314857;
      neg = 1;
    end
    for (int i = 0; i < rcm_pkg::CORDIC_STAGES && i < rcm_pkg::ATAN_ENTRIES; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(rcm_pkg::ATAN_Q28[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(rcm_pkg::ATAN_Q28[i]);
      end
      x = t;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    if (s > 65536) s = 65536;
    if (s < -65536) s = -65536;
  endfunction

  static function longint entry_q16(input longint q48);
    longint v;
    v = (q48 + 64'sd2147483648) >>> 32;
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v;
  endfunction

  function void note_pose(input logic [119:0] d);
    longint sx, cx, sy, cy, sz, cz, t;
    longint r [3][3];
    longint p [3];
    pose_matrix_t m;
    trig_q16(d[15:0], sx, cx);
    trig_q16(d[31:16], sy, cy);
    trig_q16(d[47:32], sz, cz);
    p[0] = longint'($signed(d[71:48]));
    p[1] = longint'($signed(d[95:72]));
    p[2] = longint'($signed(d[119:96]));
    r[0][0] = entry_q16(cz * cy * 65536);
    r[0][1] = entry_q16(cz * sy * sx - sz * cx * 65536);
    r[0][2] = entry_q16(cz * sy * cx + sz * sx * 65536);
    r[1][0] = entry_q16(sz * cy * 65536);
    r[1][1] = entry_q16(sz * sy * sx + cz * cx * 65536);
    r[1][2] = entry_q16(sz * sy * cx - cz * sx * 65536);
    r[2][0] = entry_q16(-sy * 65536 * 65536);
    r[2][1] = entry_q16(cy * sx * 65536);
    r[2][2] = entry_q16(cy * cx * 65536);
    for (int i = 0; i < 3; i++) begin
      t = p[i] * 65536;
      for (int j = 0; j < 3; j++) begin
        t -= r[i][j] * p[j];
        m.rot[i][j] = r[i][j][17:0];
      end
      t = (t + 32768) >>> 16;
      if (t > 134217727) t = 134217727;
      if (t < -134217728) t = -134217728;
      m.shift[i] = t[27:0];
    end
    pending.push_back(m);
  endfunction

  function void check_matrix(input logic [247:0] d);
    pose_matrix_t m;
    logic [17:0] got_r;
    logic [27:0] got_s;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result item %h", $time, d);
      errors++;
      return;
    end
    m = pending.pop_front();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        got_r = d[i*82 + j*18 +: 18];
        if (got_r !== m.rot[i][j]) begin
          $display("%0t: rot_%0d%0d expected %0d actual %0d", $time, i, j,
                   m.rot[i][j], $signed(got_r));
          errors++;
        end
      end
      got_s = d[i*82 + 54 +: 28];
      if (got_s !== m.shift[i]) begin
        $display("%0t: shift_%0d expected %0d actual %0d", $time, i,
                 m.shift[i], $signed(got_s));
        errors++;
      end
    end
    if (d[247:246] !== 2'b00) begin
      $display("%0t: pad bits expected 0 actual %b", $time, d[247:246]);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [247:0] m_axis_tdata;

  pose_scoreboard sb = new();
  int sent;
  int received;
  int idle_cycles;
  bit timed_out;
  bit send_done;

  localparam int WATCHDOG = 2000;

  always #1 clk = ~clk;

  rotation_about_center_matrix_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_pose(s_axis_tdata);
        sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_matrix(m_axis_tdata);
        received++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [119:0] pack_pose(input logic [15:0] ax, input logic [15:0] ay,
                                             input logic [15:0] az, input logic [23:0] px,
                                             input logic [23:0] py, input logic [23:0] pz);
    return {pz, py, px, az, ay, ax};
  endfunction

  // Holds valid across back-to-back items; drops it only for a gap.
  task automatic send_pose(input logic [119:0] d, input bit random_gap);
    int gap;
    gap = random_gap ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(16'h7FFF - $urandom_range(0, 40));
      1: return 16'(16'h8000 + $urandom_range(0, 40));
      2: return 16'($urandom_range(0, 40)) - 16'd20;
      3: return 16'($signed(16'($urandom_range(6430, 6440))) *
                    (($urandom_range(0, 1) != 0) ? 1 : -1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_pivot();
    case ($urandom_range(0, 4))
      0: return 24'(24'h7FFFFF - $urandom_range(0, 3));
      1: return 24'(24'h800000 + $urandom_range(0, 3));
      2: return 24'($urandom_range(0, 8192)) - 24'd4096;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dir_ang [8];
    logic [23:0] dir_piv [4];
    dir_ang = '{16'h0000, 16'h7FFF, 16'h8000, 16'd6434, -16'sd6434,
                16'd12868, -16'sd12868, 16'd3217};
    dir_piv = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h001000};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int i = 0; i < 8; i++)
      send_pose(pack_pose(dir_ang[i], dir_ang[(i + 3) % 8], dir_ang[(i + 5) % 8],
                          dir_piv[i % 4], dir_piv[(i + 1) % 4], dir_piv[(i + 2) % 4]), 0);
    for (int i = 0; i < 8; i++)
      send_pose(pack_pose(dir_ang[i], 16'h0000, 16'h0000, dir_piv[1], dir_piv[2],
                          dir_piv[1]), 1);
    send_pose(pack_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF,
                        24'h7FFFFF), 0);
    send_pose(pack_pose(16'h8000, 16'h8000, 16'h8000, 24'h800000, 24'h800000,
                        24'h800000), 0);
    send_pose(pack_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                        24'hFFFFFF), 1);
    for (int n = 0; n < 1500; n++)
      send_pose(pack_pose(rand_angle(), rand_angle(), rand_angle(), rand_pivot(),
                          rand_pivot(), rand_pivot()), (n / 200) % 2 == 0);
    s_axis_tvalid <= 0;
    send_done = 1;
  end

  // Sink: random stalls, with a stall-free stretch in the middle of the run.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = (sent > 600 && sent < 900) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    wait (send_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (rcm_pkg::TOTAL_LATENCY + 10) @(posedge clk);
    $display("Sent %0d poses, checked %0d matrices (angle wrap, saturation, pivots).",
             sent, received);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
